/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files of the windowed mean histogram.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WMH_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WMH_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/wmh_pkg.sv */
// Package with the payload types and fixed constants of the windowed mean histogram.
`timescale 1ns / 1ps

package wmh_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int BW_W      = 31;
    localparam int COUNT_W   = 32;
    localparam int SEL_W     = 3;

    localparam logic [BW_W-1:0]    BIN_WIDTH_RESET = 31'd16777216;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic                       req_type;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       window_last;
        logic                       rising;
        logic [SEL_W-1:0]           bin_select;
    } t_wmh_req;

    typedef struct packed {
        logic [SEL_W-1:0]   bin_index;
        logic [COUNT_W-1:0] occurrence_count;
        logic [COUNT_W-1:0] rising_count;
        logic [COUNT_W-1:0] total_windows;
    } t_wmh_rsp;

endpackage

/* hw/rtl/wmh_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module wmh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/window_mean_histogram.sv */
// Top level of the windowed mean histogram: window accumulation, binning and bin counters.
//
//  Channel  | Direction | Handshake                   | Payload
//  ---------+-----------+-----------------------------+-------------------------
//  request  | in        | i_valid / o_ready           | i_req (t_wmh_req)
//  response | out       | o_valid / i_ready           | o_rsp (t_wmh_rsp)
//  config   | in        | i_cfg_valid / o_cfg_ready   | i_cfg_data (bin width)
//
// A sample that does not end its window leaves the block ready, so samples stream back to back.
// A window end takes a multiply step, shared subtract-and-compare passes until the remainder
// is below the divisor or the bin offset reaches NUM_BINS/2, then fetch and update steps; a bin
// read takes only the fetch and update steps. The bin counters sit in one RAM, read and written
// back through its separate ports. Reset clears the counters at once through per-bin valid bits;
// there is no clearing pass. A pending response stalls only the update state; the config port never stalls.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module window_mean_histogram
    import wmh_pkg::*;
#(
    parameter int NUM_BINS   = 8,
    parameter int MAX_WINDOW = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_wmh_req        i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output t_wmh_rsp        o_rsp,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [BW_W-1:0] i_cfg_data
);

    localparam int HALF   = NUM_BINS / 2;
    localparam int BIN_W  = $clog2(NUM_BINS);
    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int DEN_W  = CNT_W + BW_W;
    localparam int CMP_W  = ((SUM_W > DEN_W) ? SUM_W : DEN_W) + 1;
    localparam int M_W    = $clog2(HALF + 1);
    localparam int DATA_W = 2 * COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FETCH,
        S_UPD
    } t_state;

    t_state                  r_state;
    logic [BW_W-1:0]         r_bin_width;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_cnt;
    logic [SUM_W-1:0]        r_rem;
    logic [DEN_W-1:0]        r_den;
    logic                    r_neg;
    logic [M_W-1:0]          r_m;
    logic [BIN_W-1:0]        r_idx;
    logic [SEL_W-1:0]        r_sel;
    logic                    r_is_read;
    logic                    r_oor;
    logic                    r_rising;
    logic [NUM_BINS-1:0]     r_vld;
    logic [COUNT_W-1:0]      r_total;
    logic                    r_out_valid;
    t_wmh_rsp                r_out;

    logic                    accept;
    logic                    out_free;
    logic [CMP_W-1:0]        n_diff;
    logic                    rem_ge;
    logic                    div_step;
    logic [BIN_W-1:0]        n_idx;
    logic [SUM_W-1:0]        n_mag;
    logic [DATA_W-1:0]       ram_rdata;
    logic [DATA_W-1:0]       ram_wdata;
    logic                    ram_we;
    logic                    entry_vld;
    logic [COUNT_W-1:0]      cur_occ;
    logic [COUNT_W-1:0]      cur_ris;
    logic [COUNT_W-1:0]      n_occ;
    logic [COUNT_W-1:0]      n_ris;
    logic [COUNT_W-1:0]      n_total;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

    assign accept      = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_rsp       = r_out;
    assign out_free    = !r_out_valid || i_ready;

    always_comb begin
        n_mag    = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        // One shared subtractor serves both the compare and the remainder update.
        n_diff   = CMP_W'(r_rem) - CMP_W'(r_den);
        rem_ge   = !n_diff[CMP_W-1];
        div_step = (r_m < M_W'(HALF)) && rem_ge;
        n_idx    = r_neg ? BIN_W'(HALF) - BIN_W'(r_m) : BIN_W'(HALF - 1) + BIN_W'(r_m);
    end

    always_comb begin
        entry_vld = r_vld[r_idx] && !r_oor;
        cur_occ   = entry_vld ? ram_rdata[COUNT_W-1:0] : '0;
        cur_ris   = entry_vld ? ram_rdata[DATA_W-1:COUNT_W] : '0;
        n_occ     = sat_inc(cur_occ);
        n_ris     = r_rising ? sat_inc(cur_ris) : cur_ris;
        n_total   = sat_inc(r_total);
        ram_wdata = {n_ris, n_occ};
        ram_we    = (r_state == S_UPD) && out_free && !r_is_read;
    end

    wmh_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bin_width <= BIN_WIDTH_RESET;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_vld       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bin_width <= i_cfg_data;
            end
            if ((r_state == S_UPD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_req.req_type == REQ_READ) begin
                            r_is_read <= 1'b1;
                            r_sel     <= i_req.bin_select;
                            r_idx     <= BIN_W'(i_req.bin_select);
                            r_oor     <= (32'(i_req.bin_select) >= NUM_BINS);
                            r_state   <= S_FETCH;
                        end else begin
                            // Samples beyond the window limit are dropped.
                            if (r_cnt < CNT_W'(MAX_WINDOW)) begin
                                r_sum <= r_sum + SUM_W'(i_req.sample);
                                r_cnt <= r_cnt + CNT_W'(1);
                            end
                            if (i_req.window_last) begin
                                r_is_read <= 1'b0;
                                r_oor     <= 1'b0;
                                r_rising  <= i_req.rising;
                                r_state   <= S_MUL;
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_den   <= DEN_W'(r_cnt) * DEN_W'(r_bin_width);
                    r_rem   <= n_mag;
                    r_neg   <= r_sum[SUM_W-1];
                    r_m     <= M_W'(1);
                    r_sum   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // A zero denominator always steps, so m runs up to its cap.
                    if (div_step) begin
                        r_rem <= SUM_W'(n_diff);
                        r_m   <= r_m + M_W'(1);
                    end else begin
                        r_idx   <= n_idx;
                        r_sel   <= SEL_W'(n_idx);
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (out_free) begin
                        r_out.bin_index <= r_sel;
                        if (r_is_read) begin
                            r_out.occurrence_count <= cur_occ;
                            r_out.rising_count     <= cur_ris;
                            r_out.total_windows    <= r_total;
                        end else begin
                            r_vld[r_idx]           <= 1'b1;
                            r_total                <= n_total;
                            r_out.occurrence_count <= n_occ;
                            r_out.rising_count     <= n_ris;
                            r_out.total_windows    <= n_total;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `WMH_ASSERT_SAME(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(MAX_WINDOW), "sample count exceeds window limit")

    `WMH_ASSERT_SAME(a_m_range, i_clk, i_rst_n, r_state == S_DIV, (r_m >= M_W'(1)) && (r_m <= M_W'(HALF)), "bin offset out of range")

    `WMH_ASSERT_NEXT(a_last_binning, i_clk, i_rst_n, accept && (i_req.req_type == REQ_SAMPLE) && i_req.window_last, !o_ready && (r_state == S_MUL), "window end did not start binning")

    `WMH_ASSERT_SAME(a_write_bin, i_clk, i_rst_n, ram_we, !r_oor && (32'(r_idx) < NUM_BINS), "counter write outside the bins")

endmodule
